FILE: rtl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg: shared types and constants for the periodic two-nearest search
// Widths of the seed store, the coordinate format and the distance path.
// ----------------------------------------------------------------------------
package pns_pkg;

	// seed store geometry
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// coordinate and register formats
	localparam int FRAC_BITS = 6;
	localparam int COORD_W   = 16;
	localparam int PERIOD_W  = 11;
	localparam int DIST_W    = 32;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// wrapped offset: signed, wide enough for 2*d against the period length
	localparam int OFS_W = COORD_W + 4;
	localparam int MAG_W = OFS_W - 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd2;

	// input mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// tag that follows one seed through the distance pipeline
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

FILE: rtl/pns_dist.sv
// ----------------------------------------------------------------------------
// pns_dist: wrapped squared distance pipeline
// Three stages: wrap offsets, square magnitudes, sum and saturate to 32 bits.
// ----------------------------------------------------------------------------
module pns_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pns_pkg::tag_t                     tag_s1,
	input  logic [pns_pkg::COORD_W-1:0]       query_x,
	input  logic [pns_pkg::COORD_W-1:0]       query_y,
	input  logic [pns_pkg::COORD_W-1:0]       seed_x_s1,
	input  logic [pns_pkg::COORD_W-1:0]       seed_y_s1,
	input  logic [pns_pkg::PERIOD_W-1:0]      period_x,
	input  logic [pns_pkg::PERIOD_W-1:0]      period_y,
	output pns_pkg::tag_t                     tag_s4,
	output logic [pns_pkg::DIST_W-1:0]        dist2_s4,
	output logic                              busy
);

	// wrap (a - b) once into half a period, return magnitude
	function automatic logic [pns_pkg::MAG_W-1:0] wrap_mag(
		input logic [pns_pkg::COORD_W-1:0]  a,
		input logic [pns_pkg::COORD_W-1:0]  b,
		input logic [pns_pkg::PERIOD_W-1:0] period
	);
		logic signed [pns_pkg::OFS_W-1:0] len;
		logic signed [pns_pkg::OFS_W-1:0] d;
		logic signed [pns_pkg::OFS_W-1:0] neg_len;
		len = $signed({{(pns_pkg::OFS_W - pns_pkg::PERIOD_W - pns_pkg::FRAC_BITS){1'b0}},
			period, {pns_pkg::FRAC_BITS{1'b0}}});
		neg_len = -len;
		d = $signed({{(pns_pkg::OFS_W - pns_pkg::COORD_W){1'b0}}, a})
			- $signed({{(pns_pkg::OFS_W - pns_pkg::COORD_W){1'b0}}, b});
		if ((d <<< 1) > len) begin
			d = d - len;
		end
		if ((d <<< 1) < neg_len) begin
			d = d + len;
		end
		if (d[pns_pkg::OFS_W-1]) begin
			d = -d;
		end
		return d[pns_pkg::MAG_W-1:0];
	endfunction

	pns_pkg::tag_t                   tag_s2, tag_s3, tag_s4_q;
	logic [pns_pkg::MAG_W-1:0]       mag_x_s2, mag_y_s2;
	logic [pns_pkg::SQ_W-1:0]        sq_x_s3, sq_y_s3;
	logic [pns_pkg::SUM_W-1:0]       sum_s3;
	logic [pns_pkg::DIST_W-1:0]      dist2_s4_q;

	// tag chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3   <= '0;
			tag_s4_q <= '0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			tag_s4_q <= tag_s3;
		end
	end

	// any seed still inside the stages
	assign busy = tag_s2.vld || tag_s3.vld || tag_s4_q.vld;

	// sum of squares; saturated to the result width in the last stage
	assign sum_s3 = {1'b0, sq_x_s3} + {1'b0, sq_y_s3};

	// datapath stages
	always_ff @(posedge clk) begin
		mag_x_s2 <= wrap_mag(query_x, seed_x_s1, period_x);
		mag_y_s2 <= wrap_mag(query_y, seed_y_s1, period_y);
		sq_x_s3  <= mag_x_s2 * mag_x_s2;
		sq_y_s3  <= mag_y_s2 * mag_y_s2;
		if (|sum_s3[pns_pkg::SUM_W-1:pns_pkg::DIST_W]) begin
			dist2_s4_q <= '1;
		end else begin
			dist2_s4_q <= sum_s3[pns_pkg::DIST_W-1:0];
		end
	end

	assign tag_s4   = tag_s4_q;
	assign dist2_s4 = dist2_s4_q;

endmodule

FILE: rtl/periodic_two_nearest_search.sv
// ----------------------------------------------------------------------------
// periodic_two_nearest_search: nearest and second-nearest seed on a torus
// Seed store in a synchronous memory, scanned one seed per cycle per query.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid / in_stall): mode 0 loads coord_x, coord_y into
//    seed slot entry_index and gives no result; mode 1 runs a
//    query at (coord_x, coord_y) over the first point_count slots
//  - output channel (out_valid / out_stall): one item per query holding the
//    nearest slot, its squared distance and the second squared distance
//  - configuration: cfg_we writes cfg_data into the register at cfg_index
//    (period_x, period_y, point_count); write only while idle
//  - a query with n seeds (n = min(point_count, 64)) reads the seed memory
//    once per cycle; the scan, the memory read, 3 distance stages, one
//    compare and the output load lie between accept and result, and the
//    next item is taken once the result is loaded; with no seeds the query
//    goes straight from accept to the output load
//  - in_stall is high while a query is in flight or its result waits for
//    the output register; a stalled result holds in the output register
//  - reset restores the register defaults; seed slots hold no value until
//    loaded, and a query must only cover loaded slots
// ----------------------------------------------------------------------------
module periodic_two_nearest_search (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [pns_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pns_pkg::CFG_W-1:0]         cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [pns_pkg::IDX_W-1:0]         entry_index,
	input  logic [pns_pkg::COORD_W-1:0]       coord_x,
	input  logic [pns_pkg::COORD_W-1:0]       coord_y,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pns_pkg::IDX_W-1:0]         nearest_index,
	output logic [pns_pkg::DIST_W-1:0]        nearest_dist2,
	output logic [pns_pkg::DIST_W-1:0]        runner_up_dist2
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                          state_q;
	logic [pns_pkg::PERIOD_W-1:0]        period_x_q, period_y_q;
	logic [pns_pkg::CNT_W-1:0]           point_count_q;
	logic [pns_pkg::CNT_W-1:0]           n_q, cnt_q, n_eff;
	logic [pns_pkg::COORD_W-1:0]         qx_q, qy_q;

	logic [2*pns_pkg::COORD_W-1:0]       seed_mem [pns_pkg::MAX_POINTS];
	logic [2*pns_pkg::COORD_W-1:0]       rdata_s1;
	pns_pkg::tag_t                       tag_s1, tag_s4;
	logic [pns_pkg::DIST_W-1:0]          dist2_s4;
	logic                                dist_busy;

	logic                                have_best_q, have_second_q;
	logic [pns_pkg::IDX_W-1:0]           best_idx_q;
	logic [pns_pkg::DIST_W-1:0]          best_d2_q, second_d2_q;

	logic                                in_acc, out_load, rd_en, pipe_busy;
	logic [pns_pkg::IDX_W-1:0]           out_idx_q;
	logic [pns_pkg::DIST_W-1:0]          out_d2_q, out_sec_q;
	logic                                out_valid_q;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign rd_en     = (state_q == ST_SCAN);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign pipe_busy = tag_s1.vld || dist_busy;
	assign n_eff     = (point_count_q > pns_pkg::CNT_W'(pns_pkg::MAX_POINTS))
		? pns_pkg::CNT_W'(pns_pkg::MAX_POINTS) : point_count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_x_q    <= pns_pkg::PERIOD_W'(288);
			period_y_q    <= pns_pkg::PERIOD_W'(192);
			point_count_q <= pns_pkg::CNT_W'(36);
		end else if (cfg_we) begin
			case (cfg_index)
				pns_pkg::REG_PERIOD_X: begin
					period_x_q <= cfg_data[pns_pkg::PERIOD_W-1:0];
				end
				pns_pkg::REG_PERIOD_Y: begin
					period_y_q <= cfg_data[pns_pkg::PERIOD_W-1:0];
				end
				pns_pkg::REG_POINT_COUNT: begin
					point_count_q <= cfg_data[pns_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// seed memory: load writes, scan reads are registered
	always_ff @(posedge clk) begin
		if (in_acc && mode == pns_pkg::MODE_LOAD) begin
			seed_mem[entry_index] <= {coord_x, coord_y};
		end
		if (rd_en) begin
			rdata_s1 <= seed_mem[cnt_q[pns_pkg::IDX_W-1:0]];
		end
	end

	// read tag follows the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= rd_en;
			tag_s1.idx <= cnt_q[pns_pkg::IDX_W-1:0];
		end
	end

	pns_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.query_x   (qx_q),
		.query_y   (qy_q),
		.seed_x_s1 (rdata_s1[2*pns_pkg::COORD_W-1:pns_pkg::COORD_W]),
		.seed_y_s1 (rdata_s1[pns_pkg::COORD_W-1:0]),
		.period_x  (period_x_q),
		.period_y  (period_y_q),
		.tag_s4    (tag_s4),
		.dist2_s4  (dist2_s4),
		.busy      (dist_busy)
	);

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && mode == pns_pkg::MODE_QUERY) begin
						cnt_q   <= '0;
						n_q     <= n_eff;
						state_q <= (n_eff == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query position capture
	always_ff @(posedge clk) begin
		if (in_acc && mode == pns_pkg::MODE_QUERY) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
		end
	end

	// best and second best tracking, earlier slot wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q   <= 1'b0;
			have_second_q <= 1'b0;
			best_idx_q    <= '0;
			best_d2_q     <= '1;
			second_d2_q   <= '1;
		end else if (in_acc && mode == pns_pkg::MODE_QUERY) begin
			have_best_q   <= 1'b0;
			have_second_q <= 1'b0;
			best_idx_q    <= '0;
			best_d2_q     <= '1;
			second_d2_q   <= '1;
		end else if (tag_s4.vld) begin
			if (!have_best_q || dist2_s4 < best_d2_q) begin
				if (have_best_q) begin
					second_d2_q   <= best_d2_q;
					have_second_q <= 1'b1;
				end
				best_d2_q   <= dist2_s4;
				best_idx_q  <= tag_s4.idx;
				have_best_q <= 1'b1;
			end else if (!have_second_q || dist2_s4 < second_d2_q) begin
				second_d2_q   <= dist2_s4;
				have_second_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= best_idx_q;
			out_d2_q  <= best_d2_q;
			out_sec_q <= second_d2_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign nearest_index   = out_idx_q;
	assign nearest_dist2   = out_d2_q;
	assign runner_up_dist2 = out_sec_q;

endmodule

FILE: rtl/pns_checker.sv
// ----------------------------------------------------------------------------
// pns_checker: port-level checks for periodic_two_nearest_search
// Watches the channels only; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module pns_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              mode,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [pns_pkg::IDX_W-1:0]         nearest_index,
	input  logic [pns_pkg::DIST_W-1:0]        nearest_dist2,
	input  logic [pns_pkg::DIST_W-1:0]        runner_up_dist2
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nearest_index)
			&& $stable(nearest_dist2) && $stable(runner_up_dist2))
		else $error("stalled result item changed");

	// a load never produces a result item
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == pns_pkg::MODE_LOAD && !out_valid |=> !out_valid)
		else $error("result item after a load");

	// a query keeps the input side busy on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == pns_pkg::MODE_QUERY |=> in_stall)
		else $error("input accepted right after a query");

	// the nearest distance never exceeds the second
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nearest_dist2 <= runner_up_dist2)
		else $error("nearest distance above second distance");

endmodule

bind periodic_two_nearest_search pns_checker u_pns_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.mode            (mode),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.nearest_index   (nearest_index),
	.nearest_dist2   (nearest_dist2),
	.runner_up_dist2 (runner_up_dist2)
);
